/* hdl/tbcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tbcf_pkg;

	// default widths of samples and coefficients
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEFF_WIDTH_DEF  = 24;

	// section state width, fixed
	localparam int STATE_W = 32;

	// configuration register file
	localparam int NUM_COEF  = 6;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_G0  = 3'd0,
		CFG_LOW_G1  = 3'd1,
		CFG_HIGH_G0 = 3'd2,
		CFG_HIGH_G1 = 3'd3,
		CFG_FB1     = 3'd4,
		CFG_FB2     = 3'd5
	} cfg_idx_t;

	// one multiply-accumulate operation per cycle on the shared multiplier, unless the sequencer holds for output room
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LA0,
		OP_HA0,
		OP_LA1,
		OP_LB1,
		OP_LB2,
		OP_HA1,
		OP_HB1,
		OP_HB2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LA0,
		ST_HA0,
		ST_LA1,
		ST_LB1,
		ST_LB2,
		ST_HA1,
		ST_HB1,
		ST_HB2
	} state_t;

	typedef struct packed {
		op_t  op;
		logic load_x;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_blocked;
	} status_t;

endpackage

`default_nettype wire

/* hdl/tbcf_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tbcf_sample_if #(
	parameter int SW = tbcf_pkg::SAMPLE_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface tbcf_band_if #(
	parameter int SW = tbcf_pkg::SAMPLE_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] low_band;
	logic signed [SW-1:0] high_band;
	logic signed [SW-1:0] mix;

	modport source (output valid, output low_band, output high_band, output mix, input ready);
	modport sink   (input valid, input low_band, input high_band, input mix, output ready);
endinterface

interface tbcf_cfg_if #(
	parameter int DW = tbcf_pkg::COEFF_WIDTH_DEF
);
	logic                             valid;
	logic                             ready;
	logic [tbcf_pkg::CFG_IDX_W-1:0]   index;
	logic [DW-1:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/two_band_crossover_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// two-band crossover: a lowpass and a highpass second-order section (transposed
// direct form II) fed by the same sample, sharing feedback coefficients b1, b2
//
// channels
//   samples : valid/ready stream of signed q1.23 input samples
//   bands   : valid/ready stream of low_band, high_band and mix (low minus high)
//   cfg     : register writes (index, data); always ready, write only while idle
//
// schedule
//   eight products per sample go through one shared multiplier, one per cycle
//   while the output register has room; a new sample is taken in the last
//   multiply step, so samples can follow back to back
//   the result is loaded into the output register in the LB2 step
//
// reset: coefficients and section states clear to zero, output empty
// stall: the result waits in an output register; the block only halts when a
// second result is ready while the first has not been taken

module two_band_crossover_filter #(
	parameter int SAMPLE_WIDTH = tbcf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEFF_WIDTH  = tbcf_pkg::COEFF_WIDTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tbcf_sample_if.sink  samples,
	tbcf_band_if.source  bands,
	tbcf_cfg_if.sink     cfg
);

	// coefficient register file
	logic [tbcf_pkg::NUM_COEF-1:0][COEFF_WIDTH-1:0] coefs;

	// controller to datapath
	tbcf_pkg::cmd_t    cmd;
	tbcf_pkg::status_t status;

	tbcf_cfg #(
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.coefs (coefs)
	);

	// sequencer: walks the eight multiply steps, holds before the output load
	tbcf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.status  (status),
		.in_ready(samples.ready),
		.cmd     (cmd)
	);

	// shared multiplier, rounding, accumulation, state and output registers
	tbcf_dp #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (samples.sample),
		.coefs    (coefs),
		.out_ready(bands.ready),
		.status   (status),
		.out_valid(bands.valid),
		.low_band (bands.low_band),
		.high_band(bands.high_band),
		.mix      (bands.mix)
	);

endmodule

`default_nettype wire

/* hdl/tbcf_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module tbcf_cfg #(
	parameter int COEFF_WIDTH = tbcf_pkg::COEFF_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tbcf_cfg_if.sink  cfg,
	output logic [tbcf_pkg::NUM_COEF-1:0][COEFF_WIDTH-1:0] coefs
);

	logic [tbcf_pkg::NUM_COEF-1:0][COEFF_WIDTH-1:0] coefs_q;

	assign cfg.ready = 1'b1;
	assign coefs     = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				tbcf_pkg::CFG_LOW_G0:  coefs_q[tbcf_pkg::CFG_LOW_G0]  <= cfg.data;
				tbcf_pkg::CFG_LOW_G1:  coefs_q[tbcf_pkg::CFG_LOW_G1]  <= cfg.data;
				tbcf_pkg::CFG_HIGH_G0: coefs_q[tbcf_pkg::CFG_HIGH_G0] <= cfg.data;
				tbcf_pkg::CFG_HIGH_G1: coefs_q[tbcf_pkg::CFG_HIGH_G1] <= cfg.data;
				tbcf_pkg::CFG_FB1:     coefs_q[tbcf_pkg::CFG_FB1]     <= cfg.data;
				tbcf_pkg::CFG_FB2:     coefs_q[tbcf_pkg::CFG_FB2]     <= cfg.data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/tbcf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tbcf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire tbcf_pkg::status_t status,
	output logic                   in_ready,
	output tbcf_pkg::cmd_t         cmd
);

	tbcf_pkg::state_t state_q;
	tbcf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.op       = tbcf_pkg::OP_NOP;
		cmd.load_x   = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			tbcf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_x = 1'b1;
					state_d    = tbcf_pkg::ST_LA0;
				end
			end
			tbcf_pkg::ST_LA0: begin
				cmd.op  = tbcf_pkg::OP_LA0;
				state_d = tbcf_pkg::ST_HA0;
			end
			tbcf_pkg::ST_HA0: begin
				cmd.op  = tbcf_pkg::OP_HA0;
				state_d = tbcf_pkg::ST_LA1;
			end
			tbcf_pkg::ST_LA1: begin
				cmd.op  = tbcf_pkg::OP_LA1;
				state_d = tbcf_pkg::ST_LB1;
			end
			tbcf_pkg::ST_LB1: begin
				cmd.op  = tbcf_pkg::OP_LB1;
				state_d = tbcf_pkg::ST_LB2;
			end
			tbcf_pkg::ST_LB2: begin
				// both bands are known here; wait for room in the output register
				if (!status.out_blocked) begin
					cmd.op       = tbcf_pkg::OP_LB2;
					cmd.load_out = 1'b1;
					state_d      = tbcf_pkg::ST_HA1;
				end
			end
			tbcf_pkg::ST_HA1: begin
				cmd.op  = tbcf_pkg::OP_HA1;
				state_d = tbcf_pkg::ST_HB1;
			end
			tbcf_pkg::ST_HB1: begin
				cmd.op  = tbcf_pkg::OP_HB1;
				state_d = tbcf_pkg::ST_HB2;
			end
			tbcf_pkg::ST_HB2: begin
				cmd.op   = tbcf_pkg::OP_HB2;
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_x = 1'b1;
					state_d    = tbcf_pkg::ST_LA0;
				end else begin
					state_d = tbcf_pkg::ST_IDLE;
				end
			end
			default: state_d = tbcf_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/tbcf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tbcf_dp #(
	parameter int SAMPLE_WIDTH = tbcf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEFF_WIDTH  = tbcf_pkg::COEFF_WIDTH_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire tbcf_pkg::cmd_t                                cmd,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                sample,
	input  wire logic [tbcf_pkg::NUM_COEF-1:0][COEFF_WIDTH-1:0] coefs,
	input  wire logic                                          out_ready,
	output tbcf_pkg::status_t                                  status,
	output logic                                               out_valid,
	output logic signed [SAMPLE_WIDTH-1:0]                     low_band,
	output logic signed [SAMPLE_WIDTH-1:0]                     high_band,
	output logic signed [SAMPLE_WIDTH-1:0]                     mix
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = COEFF_WIDTH;
	localparam int STW = tbcf_pkg::STATE_W;
	localparam int PW  = SW + CW;
	localparam int CS  = CW - 2;
	localparam int RW  = PW + 1 - CS;
	localparam int AW  = ((RW > STW) ? RW : STW) + 2;

	localparam logic [PW:0] HALF = {{(PW - CS + 1){1'b0}}, 1'b1, {(CS - 1){1'b0}}};

	function automatic logic signed [AW-1:0] ext_r(input logic signed [RW-1:0] v);
		return {{(AW - RW){v[RW-1]}}, v};
	endfunction

	function automatic logic signed [AW-1:0] ext_st(input logic signed [STW-1:0] v);
		return {{(AW - STW){v[STW-1]}}, v};
	endfunction

	function automatic logic signed [AW-1:0] ext_s(input logic signed [SW-1:0] v);
		return {{(AW - SW){v[SW-1]}}, v};
	endfunction

	function automatic logic signed [SW-1:0] sat_smp(input logic signed [AW-1:0] v);
		if ((&v[AW-1:SW-1]) || !(|v[AW-1:SW-1])) begin
			return v[SW-1:0];
		end else if (v[AW-1]) begin
			return {1'b1, {(SW - 1){1'b0}}};
		end else begin
			return {1'b0, {(SW - 1){1'b1}}};
		end
	endfunction

	function automatic logic signed [STW-1:0] sat_st(input logic signed [AW-1:0] v);
		if ((&v[AW-1:STW-1]) || !(|v[AW-1:STW-1])) begin
			return v[STW-1:0];
		end else if (v[AW-1]) begin
			return {1'b1, {(STW - 1){1'b0}}};
		end else begin
			return {1'b0, {(STW - 1){1'b1}}};
		end
	endfunction

	logic signed [SW-1:0]  x_q;
	logic signed [CW-1:0]  coef_mux;
	logic signed [SW-1:0]  opnd_mux;
	logic signed [PW-1:0]  prod_s1;
	tbcf_pkg::op_t         op_s1;
	logic signed [PW:0]    psum;
	logic signed [RW-1:0]  rnd;

	logic signed [RW-1:0]  rl0_q;
	logic signed [RW-1:0]  rh0_q;
	logic signed [AW-1:0]  accl_q;
	logic signed [AW-1:0]  acch_q;
	logic signed [SW-1:0]  yl_q;
	logic signed [SW-1:0]  yh_q;
	logic signed [STW-1:0] ld1_q;
	logic signed [STW-1:0] ld2_q;
	logic signed [STW-1:0] hd1_q;
	logic signed [STW-1:0] hd2_q;

	logic                  out_valid_q;
	logic signed [SW-1:0]  low_q;
	logic signed [SW-1:0]  high_q;
	logic signed [SW-1:0]  mix_q;

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= sample;
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		coef_mux = '0;
		opnd_mux = x_q;
		case (cmd.op)
			tbcf_pkg::OP_LA0: coef_mux = coefs[tbcf_pkg::CFG_LOW_G0];
			tbcf_pkg::OP_HA0: coef_mux = coefs[tbcf_pkg::CFG_HIGH_G0];
			tbcf_pkg::OP_LA1: coef_mux = coefs[tbcf_pkg::CFG_LOW_G1];
			tbcf_pkg::OP_HA1: coef_mux = coefs[tbcf_pkg::CFG_HIGH_G1];
			tbcf_pkg::OP_LB1: begin
				coef_mux = coefs[tbcf_pkg::CFG_FB1];
				opnd_mux = yl_q;
			end
			tbcf_pkg::OP_LB2: begin
				coef_mux = coefs[tbcf_pkg::CFG_FB2];
				opnd_mux = yl_q;
			end
			tbcf_pkg::OP_HB1: begin
				coef_mux = coefs[tbcf_pkg::CFG_FB1];
				opnd_mux = yh_q;
			end
			tbcf_pkg::OP_HB2: begin
				coef_mux = coefs[tbcf_pkg::CFG_FB2];
				opnd_mux = yh_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef_mux * opnd_mux;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= tbcf_pkg::OP_NOP;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	// round half up to state lsb
	assign psum = $signed({prod_s1[PW-1], prod_s1}) + $signed(HALF);
	assign rnd  = psum[PW:CS];

	// accumulate stage, working on the registered product in the cycle after the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl0_q  <= '0;
			rh0_q  <= '0;
			accl_q <= '0;
			acch_q <= '0;
			yl_q   <= '0;
			yh_q   <= '0;
			ld1_q  <= '0;
			ld2_q  <= '0;
			hd1_q  <= '0;
			hd2_q  <= '0;
		end else begin
			case (op_s1)
				tbcf_pkg::OP_LA0: rl0_q <= rnd;
				tbcf_pkg::OP_HA0: begin
					rh0_q <= rnd;
					yl_q  <= sat_smp(ext_r(rl0_q) + ext_st(ld1_q));
				end
				tbcf_pkg::OP_LA1: begin
					accl_q <= ext_r(rnd) + ext_st(ld2_q);
					yh_q   <= sat_smp(ext_r(rh0_q) + ext_st(hd1_q));
				end
				tbcf_pkg::OP_LB1: ld1_q  <= sat_st(accl_q - ext_r(rnd));
				tbcf_pkg::OP_LB2: ld2_q  <= sat_st(ext_r(rl0_q) - ext_r(rnd));
				tbcf_pkg::OP_HA1: acch_q <= ext_r(rnd) + ext_st(hd2_q);
				tbcf_pkg::OP_HB1: hd1_q  <= sat_st(acch_q - ext_r(rnd));
				tbcf_pkg::OP_HB2: hd2_q  <= sat_st(ext_r(rh0_q) - ext_r(rnd));
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			low_q  <= yl_q;
			high_q <= yh_q;
			mix_q  <= sat_smp(ext_s(yl_q) - ext_s(yh_q));
		end
	end

	assign status.out_blocked = out_valid_q && !out_ready;
	assign out_valid          = out_valid_q;
	assign low_band           = low_q;
	assign high_band          = high_q;
	assign mix                = mix_q;

endmodule

`default_nettype wire

/* hdl/tbcf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tbcf_checker #(
	parameter int SW = tbcf_pkg::SAMPLE_WIDTH_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire logic [SW-1:0] low_band,
	input wire logic [SW-1:0] high_band,
	input wire logic [SW-1:0] mix
);

	// a pending result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a pending result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(low_band) && $stable(high_band) && $stable(mix))
		else $error("result payload changed while stalled");

	// a sample transaction starts the multiply sequence, no second one right after
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken twice in a row");

	// a fresh result must trace back to an earlier sample transaction
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 6))
		else $error("result without matching sample");

endmodule

bind two_band_crossover_filter tbcf_checker #(
	.SW(SAMPLE_WIDTH)
) u_tbcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(bands.valid),
	.out_ready(bands.ready),
	.low_band (bands.low_band),
	.high_band(bands.high_band),
	.mix      (bands.mix)
);

`default_nettype wire

/* dv/two_band_crossover_filter_tb.sv */
`timescale 1ns / 1ps
`default_nettype none

module two_band_crossover_filter_tb;

	import tbcf_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int CW = COEFF_WIDTH_DEF;

	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [CW-1:0]        COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0]        COEF_MIN   = {1'b1, {(CW-1){1'b0}}};

	// second-order crossover with a double pole at 0.9, q2.22
	localparam logic [CW-1:0] XO_LOW_A0  = CW'(10486);
	localparam logic [CW-1:0] XO_LOW_A1  = CW'(20972);
	localparam logic [CW-1:0] XO_HIGH_A0 = CW'(3785359);
	localparam logic [CW-1:0] XO_HIGH_A1 = CW'(-7570719);
	localparam logic [CW-1:0] XO_FB1     = CW'(-7549747);
	localparam logic [CW-1:0] XO_FB2     = CW'(3397386);

	// section slots in the predictor state
	localparam int LOW_SEC  = 0;
	localparam int HIGH_SEC = 1;

	// receiver back-pressure patterns
	typedef enum int {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE,
		RX_BURSTY
	} rx_mode_t;

	typedef struct {
		logic signed [SW-1:0] low_band;
		logic signed [SW-1:0] high_band;
		logic signed [SW-1:0] mix;
	} band_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tbcf_sample_if #(.SW(SW)) sample_ch ();
	tbcf_band_if   #(.SW(SW)) band_ch ();
	tbcf_cfg_if    #(.DW(CW)) coef_ch ();

	two_band_crossover_filter #(
		.SAMPLE_WIDTH(SW),
		.COEFF_WIDTH (CW)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sample_ch),
		.bands  (band_ch),
		.cfg    (coef_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the coefficient registers and section states
	longint coef_reg [NUM_COEF];
	longint delay_first [2];
	longint delay_second [2];

	// band results still owed by the block, oldest first
	band_result_t bands_due[$];

	int samples_sent    = 0;
	int results_checked = 0;
	int coef_sets       = 0;
	int fail_count      = 0;

	// ---------------------------------------------------------------
	// crossover predictor
	// ---------------------------------------------------------------

	function automatic longint clamp_to(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// product back to sample lsb units, half rounds toward plus infinity
	function automatic longint rescale(longint c, longint x);
		return (c * x + (longint'(1) <<< (CW - 3))) >>> (CW - 2);
	endfunction

	// one transposed direct form ii section with a0 = a2
	function automatic longint run_section(int sec, longint x, longint g0, longint g1);
		longint y, n1, n2;
		// saturated output drives the feedback terms
		y  = clamp_to(rescale(g0, x) + delay_first[sec], SW);
		n1 = rescale(g1, x) - rescale(coef_reg[CFG_FB1], y) + delay_second[sec];
		n2 = rescale(g0, x) - rescale(coef_reg[CFG_FB2], y);
		delay_first[sec]  = clamp_to(n1, STATE_W);
		delay_second[sec] = clamp_to(n2, STATE_W);
		return y;
	endfunction

	function automatic void predict_bands(logic signed [SW-1:0] s);
		longint       x, lo, hi, mx;
		band_result_t r;
		x  = s;
		lo = run_section(LOW_SEC, x, coef_reg[CFG_LOW_G0], coef_reg[CFG_LOW_G1]);
		hi = run_section(HIGH_SEC, x, coef_reg[CFG_HIGH_G0], coef_reg[CFG_HIGH_G1]);
		// mix comes from the already saturated bands
		mx = clamp_to(lo - hi, SW);
		r.low_band  = lo[SW-1:0];
		r.high_band = hi[SW-1:0];
		r.mix       = mx[SW-1:0];
		bands_due.push_back(r);
	endfunction

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	function automatic void check_field(string name, logic signed [SW-1:0] want,
	                                    logic signed [SW-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// each band transaction is matched against the oldest prediction
	always @(posedge clk) begin : check_bands
		band_result_t due;
		if (arst_n && band_ch.valid && band_ch.ready) begin
			results_checked++;
			if (bands_due.size() == 0) begin
				$error("band transaction with no prediction pending");
				fail_count++;
			end else begin
				due = bands_due.pop_front();
				check_field("low_band", due.low_band, band_ch.low_band);
				check_field("high_band", due.high_band, band_ch.high_band);
				check_field("mix", due.mix, band_ch.mix);
			end
		end
	end

	// receiver: switches between back-pressure patterns every so often,
	// steady stretches included
	initial begin : band_receiver
		rx_mode_t mode;
		int       left;
		mode = RX_STEADY;
		left = 0;
		band_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(16, 200);
			end
			left--;
			case (mode)
				RX_STEADY: band_ch.ready <= 1'b1;
				RX_COIN:   band_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: band_ch.ready <= ($urandom_range(0, 7) == 0);
				default:   band_ch.ready <= ((left % 40) >= 30);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// valid is left high so a following sample can go back to back
	task automatic send_sample(logic signed [SW-1:0] s);
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		do @(posedge clk); while (!sample_ch.ready);
		predict_bands(s);
		samples_sent++;
	endtask

	task automatic idle_sender(int cycles);
		sample_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// hold off until every predicted band result has been taken and the
	// high section has finished its state update behind the last result
	task automatic wait_drain();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (bands_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
		coef_ch.valid <= 1'b1;
		coef_ch.index <= idx;
		coef_ch.data  <= val;
		do @(posedge clk); while (!coef_ch.ready);
		// unmapped indexes leave the register file untouched
		if (idx < NUM_COEF)
			coef_reg[idx] = longint'(signed'(val));
	endtask

	// all six registers, written only once the block has gone idle
	task automatic load_coefs(logic [CW-1:0] l0, logic [CW-1:0] l1, logic [CW-1:0] h0,
	                          logic [CW-1:0] h1, logic [CW-1:0] f1, logic [CW-1:0] f2);
		wait_drain();
		write_coef(CFG_LOW_G0, l0);
		write_coef(CFG_LOW_G1, l1);
		write_coef(CFG_HIGH_G0, h0);
		write_coef(CFG_HIGH_G1, h1);
		write_coef(CFG_FB1, f1);
		write_coef(CFG_FB2, f2);
		coef_ch.valid <= 1'b0;
		coef_sets++;
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		logic signed [SW-1:0] v;
		case ($urandom_range(0, 9))
			0: v = SAMPLE_MAX;
			1: v = SAMPLE_MIN;
			2: v = SW'($urandom_range(0, 1023)) - SW'(512);
			default: v = SW'($urandom);
		endcase
		return v;
	endfunction

	// half full range, half modest values that keep the filter calmer
	function automatic logic [CW-1:0] pick_coef();
		if ($urandom_range(0, 1))
			return CW'($urandom);
		return CW'($urandom_range(0, 1 << 21) - (1 << 20));
	endfunction

	// random samples in bursts, with or without idle gaps between them, so that new
	// samples land on every phase of the multiply schedule
	task automatic stream_samples(int n, bit with_drains);
		int left, burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			repeat (burst) send_sample(pick_sample());
			left -= burst;
			case ($urandom_range(0, 7))
				0, 1: ;
				2: begin
					if (with_drains)
						wait_drain();
					else
						idle_sender($urandom_range(1, 3));
				end
				default: idle_sender($urandom_range(1, 12));
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	task automatic apply_reset();
		foreach (coef_reg[i]) coef_reg[i] = 0;
		foreach (delay_first[i]) begin
			delay_first[i]  = 0;
			delay_second[i] = 0;
		end
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		coef_ch.valid    <= 1'b0;
		coef_ch.index    <= '0;
		coef_ch.data     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// coefficients clear to zero, so every band must come out zero
	task automatic test_reset_values();
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('0);
		send_sample('1);
		wait_drain();
	endtask

	// writes to indexes past the register file are dropped
	task automatic test_unmapped_index();
		write_coef(CFG_IDX_W'(NUM_COEF), COEF_MAX);
		write_coef(CFG_IDX_W'(NUM_COEF + 1), '1);
		coef_ch.valid <= 1'b0;
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		wait_drain();
	endtask

	// full-scale coefficients and samples: outputs, states and mix all clip
	task automatic test_saturation();
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample('1);
		send_sample('0);
		load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SW'(1));
		idle_sender(3);
		send_sample(SAMPLE_MIN);
		send_sample('0);
		// opposite band gains push the mix into both rails
		load_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SW'(1));
		send_sample('1);
		wait_drain();
	endtask

	// a well-behaved crossover with random program material
	task automatic test_crossover_stream();
		load_coefs(XO_LOW_A0, XO_LOW_A1, XO_HIGH_A0, XO_HIGH_A1, XO_FB1, XO_FB2);
		stream_samples(350, 1'b0);
	endtask

	task automatic test_random_coefs();
		repeat (8) begin
			load_coefs(pick_coef(), pick_coef(), pick_coef(),
			           pick_coef(), pick_coef(), pick_coef());
			stream_samples(60, 1'b0);
		end
	endtask

	// sender stops now and then until the block has emptied
	task automatic test_drain_pauses();
		load_coefs(XO_LOW_A0, XO_LOW_A1, XO_HIGH_A0, XO_HIGH_A1, XO_FB1, XO_FB2);
		stream_samples(120, 1'b1);
	endtask

	initial begin
		apply_reset();
		test_reset_values();
		test_unmapped_index();
		test_saturation();
		test_crossover_stream();
		test_random_coefs();
		test_drain_pauses();
		wait_drain();
		repeat (16) @(posedge clk);
		$display("run covered %0d samples and %0d band results over %0d coefficient sets",
		         samples_sent, results_checked, coef_sets);
		$display("including reset values, unmapped writes, full-scale clipping and drains");
		if (fail_count == 0) begin
			$display("[two_band_crossover_filter] OK");
		end else begin
			$display("[two_band_crossover_filter] ERROR");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("timeout with %0d band results outstanding", bands_due.size());
		$display("[two_band_crossover_filter] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
